[design/b64d_pkg.sv]
package b64d_pkg;

  localparam int unsigned CmdDepth = 2;
  localparam int unsigned CmdPtrW  = (CmdDepth > 1) ? $clog2(CmdDepth) : 1;
  localparam int unsigned CmdCntW  = $clog2(CmdDepth + 1);

  localparam logic [7:0] PadChar = 8'h3D;  // '='

  // One queued job for the back end: up to three result transfers.
  typedef struct packed {
    logic [23:0] bytes;        // first byte in the top bits
    logic [1:0]  last_idx;     // number of results minus one
    logic        has_bytes;
    logic        end_mark;     // set on the last result only
    logic        parse_error;
  } b64d_cmd_t;

  // {valid, sextet} for a standard-alphabet character
  function automatic logic [6:0] sextet_of(input logic [7:0] c);
    logic [7:0] v;
    logic       ok;
    v  = 8'd0;
    ok = 1'b1;
    if (c >= 8'h41 && c <= 8'h5A) begin
      v = c - 8'h41;
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      v = c - 8'h61 + 8'd26;
    end else if (c >= 8'h30 && c <= 8'h39) begin
      v = c - 8'h30 + 8'd52;
    end else if (c == 8'h2B) begin
      v = 8'd62;
    end else if (c == 8'h2F) begin
      v = 8'd63;
    end else begin
      ok = 1'b0;
    end
    return {ok, v[5:0]};
  endfunction

endpackage

[design/b64d_front.sv]
module b64d_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  logic [7:0]         char_i,
  input  logic               final_i,
  input  logic               full_i,
  output logic               push_o,
  output b64d_pkg::b64d_cmd_t cmd_o
);
  import b64d_pkg::*;

  logic [17:0] accum_q, accum_d;
  logic [1:0]  count_q, count_d;
  logic        pad_q, pad_d;
  logic        ginv_q, ginv_d;
  logic        errl_q, errl_d;

  logic        accept;
  logic [6:0]  sx;
  logic        inv_n;
  logic        err;
  logic        want;
  logic        clear;

  assign ready_o = !full_i;
  assign accept  = valid_i && ready_o;
  assign sx      = sextet_of(char_i);
  assign inv_n   = ginv_q | ~sx[6];

  always_comb begin
    accum_d = accum_q;
    count_d = count_q;
    pad_d   = pad_q;
    ginv_d  = ginv_q;
    errl_d  = errl_q;
    err     = 1'b0;
    want    = 1'b0;
    clear   = 1'b0;
    cmd_o   = '0;

    if (errl_q) begin
      if (final_i) begin
        want              = 1'b1;
        clear             = 1'b1;
        cmd_o.end_mark    = 1'b1;
        cmd_o.parse_error = 1'b1;
      end
    end else begin
      if (char_i == PadChar) begin
        pad_d = 1'b1;
      end else if (pad_q) begin
        err = 1'b1;
      end else if (count_q == 2'd3) begin
        if (inv_n) begin
          err = 1'b1;
        end else begin
          want            = 1'b1;
          cmd_o.bytes     = {accum_q, sx[5:0]};
          cmd_o.last_idx  = 2'd2;
          cmd_o.has_bytes = 1'b1;
        end
        accum_d = '0;
        count_d = 2'd0;
        ginv_d  = 1'b0;
      end else begin
        accum_d = {accum_q[11:0], sx[5:0]};
        count_d = count_q + 2'd1;
        ginv_d  = inv_n;
      end

      // end of string: flush a tail of two or three sextets
      if (!err && final_i && (count_d == 2'd2 || count_d == 2'd3)) begin
        if (ginv_d) begin
          err = 1'b1;
        end else if (count_d == 2'd2) begin
          want            = 1'b1;
          cmd_o.bytes     = {accum_d[11:4], 16'd0};
          cmd_o.last_idx  = 2'd0;
          cmd_o.has_bytes = 1'b1;
        end else begin
          want            = 1'b1;
          cmd_o.bytes     = {accum_d[17:10], accum_d[9:2], 8'd0};
          cmd_o.last_idx  = 2'd1;
          cmd_o.has_bytes = 1'b1;
        end
      end

      if (err) begin
        want              = 1'b1;
        cmd_o             = '0;
        cmd_o.parse_error = 1'b1;
        cmd_o.end_mark    = final_i;
        errl_d            = !final_i;
        clear             = final_i;
      end else if (final_i) begin
        want           = 1'b1;
        clear          = 1'b1;
        cmd_o.end_mark = 1'b1;
      end
    end

    if (clear) begin
      accum_d = '0;
      count_d = 2'd0;
      pad_d   = 1'b0;
      ginv_d  = 1'b0;
      errl_d  = 1'b0;
    end
  end

  assign push_o = accept && want;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accum_q <= '0;
      count_q <= 2'd0;
      pad_q   <= 1'b0;
      ginv_q  <= 1'b0;
      errl_q  <= 1'b0;
    end else if (accept) begin
      accum_q <= accum_d;
      count_q <= count_d;
      pad_q   <= pad_d;
      ginv_q  <= ginv_d;
      errl_q  <= errl_d;
    end
  end

endmodule

[design/b64d_fifo.sv]
module b64d_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  b64d_pkg::b64d_cmd_t cmd_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                empty_o,
  output b64d_pkg::b64d_cmd_t head_o
);
  import b64d_pkg::*;

  b64d_cmd_t          mem_q [CmdDepth];
  logic [CmdPtrW-1:0] wr_q, rd_q;
  logic [CmdCntW-1:0] cnt_q;
  logic               do_push, do_pop;

  assign full_o  = (cnt_q == CmdCntW'(CmdDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == CmdPtrW'(CmdDepth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == CmdPtrW'(CmdDepth - 1)) ? '0 : rd_q + 1'b1;
      end
      cnt_q <= cnt_q + CmdCntW'(do_push) - CmdCntW'(do_pop);
    end
  end

endmodule

[design/b64d_back.sv]
module b64d_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                empty_i,
  input  b64d_pkg::b64d_cmd_t head_i,
  output logic                pop_o,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [7:0]          m_axis_tdata_o,
  output logic                m_axis_tlast_o,
  output logic [1:0]          m_axis_tuser_o
);
  import b64d_pkg::*;

  logic [1:0] idx_q;
  logic       vld_q;
  logic [7:0] data_q;
  logic       last_q;
  logic [1:0] user_q;
  logic       load;
  logic       at_last;
  logic [7:0] sel;

  assign load    = !empty_i && (!vld_q || m_axis_tready_i);
  assign at_last = (idx_q == head_i.last_idx);
  assign pop_o   = load && at_last;

  always_comb begin
    unique case (idx_q)
      2'd0:    sel = head_i.bytes[23:16];
      2'd1:    sel = head_i.bytes[15:8];
      default: sel = head_i.bytes[7:0];
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 2'd0;
      vld_q <= 1'b0;
    end else begin
      if (load) begin
        idx_q <= at_last ? 2'd0 : idx_q + 2'd1;
        vld_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= sel;
      last_q <= head_i.end_mark && at_last;
      user_q <= {head_i.parse_error, head_i.has_bytes};
    end
  end

  assign m_axis_tvalid_o = vld_q;
  assign m_axis_tdata_o  = data_q;
  assign m_axis_tlast_o  = last_q;
  assign m_axis_tuser_o  = user_q;

  // index never runs past the job it is walking through
  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_i |-> idx_q <= head_i.last_idx)
    else $error("result index beyond job");

  // with no job pending the index sits at the first result
  a_idx_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_i |-> idx_q == 2'd0)
    else $error("stale result index");

  // a transfer without a byte carries zero data
  a_zero_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q && !user_q[0]) |-> data_q == 8'd0)
    else $error("data on a byte-less transfer");

endmodule

[design/base64_stream_decoder_core.sv]
// Base64 stream decoder, standard alphabet.
// Slave channel: one character per transfer in s_axis_tdata_i, s_axis_tlast_i
// marks the last character of a string. Master channel: one result per
// transfer; tdata is the decoded byte, tuser[0] says it is a real byte,
// tuser[1] flags a parse error, tlast marks the final result of a string.
// Every complete group of four characters gives three byte transfers; at the
// end of a string a tail gives one or two more, or a lone byte-less end
// transfer. An error gives one error transfer, then silence until the end.
// A character's job is written into the job queue at the edge that takes the
// character; the back end then loads it into the output register, from which
// its results leave. Throughput: one character per cycle, and one result per
// cycle while the sink is ready; the front end only waits while the two-entry
// job queue is full, which happens when the sink stalls or a group's three
// results are closely followed by more jobs.
// Reset clears the group state, the queue and the output valid at once.
// A stalled sink holds the current result steady; the queue absorbs further
// jobs, and once it is full s_axis_tready_o drops until space frees up.
module base64_stream_decoder_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] char_in
  input  logic       s_axis_tlast_i,   // is_final
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] data_byte
  output logic       m_axis_tlast_o,   // end_mark
  output logic [1:0] m_axis_tuser_o    // [0] byte_valid, [1] parse_error
);
  import b64d_pkg::*;

  b64d_cmd_t push_cmd, head_cmd;
  logic      push, full, pop, empty;

  // classify characters, keep group state, emit jobs
  b64d_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid_i),
    .ready_o (s_axis_tready_o),
    .char_i  (s_axis_tdata_i),
    .final_i (s_axis_tlast_i),
    .full_i  (full),
    .push_o  (push),
    .cmd_o   (push_cmd)
  );

  // short job queue decoupling the two halves
  b64d_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .head_o  (head_cmd)
  );

  // split each job into result transfers
  b64d_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .empty_i         (empty),
    .head_i          (head_cmd),
    .pop_o           (pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

endmodule

[sim/base64_stream_decoder_core_tb.sv]
`timescale 1ns / 1ps

module base64_stream_decoder_core_tb;
  import b64d_pkg::*;

  localparam int unsigned ResetCycles   = 11;
  localparam int unsigned TailCycles    = 10;
  localparam int unsigned SinkHoldCycles = 150;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned PhaseChars    = 32;
  localparam int unsigned NumDirected   = 25;

  // One result transfer as seen on the master side.
  typedef struct packed {
    logic [7:0] data;
    logic       bvalid;
    logic       endm;
    logic       perr;
  } b64_result_t;

  localparam b64_result_t NoCheck = '0;
  localparam b64_result_t EndOnly = '{8'h00, 1'b0, 1'b1, 1'b0};  // end, no bytes
  localparam b64_result_t ErrMark = '{8'h00, 1'b0, 1'b0, 1'b1};  // error mid-string
  localparam b64_result_t ErrEnd  = '{8'h00, 1'b0, 1'b1, 1'b1};  // error at the end

  typedef struct packed {
    logic [7:0]  ch;
    logic        fin;
    logic        typed;  // use want below instead of the decoder model
    b64_result_t want;
  } dir_row_t;

  logic       clk_i;
  logic       rst_ni        = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready_o;
  logic [7:0] s_axis_tdata  = 8'h00;
  logic       s_axis_tlast  = 1'b0;
  logic       m_axis_tvalid_o;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata_o;
  logic       m_axis_tlast_o;
  logic [1:0] m_axis_tuser_o;

  // decoder model state
  logic [17:0] sx_acc   = '0;
  logic [1:0]  grp_cnt  = '0;
  logic        pad_seen = 1'b0;
  logic        grp_bad  = 1'b0;
  logic        err_held = 1'b0;

  b64_result_t step_results [$];
  b64_result_t exp_results [$];
  dir_row_t    dir_tab [NumDirected];

  int unsigned fail_count    = 0;
  int unsigned chars_sent    = 0;
  int unsigned stuck_cycles  = 0;
  int unsigned src_idle_pct  = 0;
  int unsigned snk_stall_pct = 0;
  logic        hold_req      = 1'b0;
  logic        hold_done     = 1'b0;

  base64_stream_decoder_core u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tlast_i  (s_axis_tlast),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic int char_to_sextet(input logic [7:0] c);
    if (c >= "A" && c <= "Z") return int'(c - "A");
    if (c >= "a" && c <= "z") return int'(c - "a") + 26;
    if (c >= "0" && c <= "9") return int'(c - "0") + 52;
    if (c == "+") return 62;
    if (c == "/") return 63;
    return -1;
  endfunction

  function automatic logic [7:0] sextet_to_char(input int unsigned v);
    if (v < 26) return 8'("A" + v);
    if (v < 52) return 8'("a" + v - 26);
    if (v < 62) return 8'("0" + v - 52);
    if (v == 62) return "+";
    return "/";
  endfunction

  function automatic void clear_decoder();
    sx_acc   = '0;
    grp_cnt  = '0;
    pad_seen = 1'b0;
    grp_bad  = 1'b0;
    err_held = 1'b0;
  endfunction

  function automatic void push_byte(input logic [7:0] b);
    step_results.push_back('{b, 1'b1, 1'b0, 1'b0});
  endfunction

  // Works out the result transfers one character causes; leaves them in step_results.
  function automatic void decode_char(input logic [7:0] c, input logic fin);
    int          sx;
    logic [5:0]  s;
    logic [23:0] word;
    logic        bad;
    b64_result_t last_res;
    step_results.delete();
    if (err_held) begin
      // error already reported: silent until the end of the string
      if (fin) begin
        step_results.push_back(ErrEnd);
        clear_decoder();
      end
      return;
    end
    bad = 1'b0;
    if (c == PadChar) begin
      pad_seen = 1'b1;
    end else if (pad_seen) begin
      bad = 1'b1;
    end else begin
      sx = char_to_sextet(c);
      s  = (sx < 0) ? 6'd0 : sx[5:0];
      if (sx < 0) grp_bad = 1'b1;
      if (grp_cnt == 2'd3) begin
        if (grp_bad) begin
          bad = 1'b1;
        end else begin
          word = {sx_acc, s};
          push_byte(word[23:16]);
          push_byte(word[15:8]);
          push_byte(word[7:0]);
        end
        sx_acc  = '0;
        grp_cnt = '0;
        grp_bad = 1'b0;
      end else begin
        sx_acc  = {sx_acc[11:0], s};
        grp_cnt = grp_cnt + 2'd1;
      end
    end
    // tail of two or three sextets; a lone one is dropped unchecked
    if (!bad && fin && grp_cnt >= 2'd2) begin
      if (grp_bad) begin
        bad = 1'b1;
      end else if (grp_cnt == 2'd2) begin
        push_byte(sx_acc[11:4]);
      end else begin
        push_byte(sx_acc[17:10]);
        push_byte(sx_acc[9:2]);
      end
    end
    if (bad) begin
      step_results.delete();
      step_results.push_back(fin ? ErrEnd : ErrMark);
      if (fin) clear_decoder();
      else err_held = 1'b1;
    end else if (fin) begin
      if (step_results.size() == 0) begin
        step_results.push_back(EndOnly);
      end else begin
        last_res      = step_results.pop_back();
        last_res.endm = 1'b1;
        step_results.push_back(last_res);
      end
      clear_decoder();
    end
  endfunction

  task automatic send_char(input logic [7:0] c, input logic fin, input logic typed,
                           input b64_result_t want);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    s_axis_tlast  <= fin;
    do @(posedge clk_i); while (!s_axis_tready_o);
    decode_char(c, fin);
    if (typed) begin
      exp_results.push_back(want);
    end else begin
      foreach (step_results[i]) exp_results.push_back(step_results[i]);
    end
    chars_sent++;
  endtask

  // Mostly well-formed strings with random content; the rest noise or spoilt.
  task automatic send_string();
    logic [7:0]  txt [$];
    int unsigned len;
    int unsigned pads;
    int unsigned kind;
    int unsigned pos;
    kind = $urandom_range(99);
    len  = ($urandom_range(9) == 0) ? $urandom_range(14, 24) : $urandom_range(1, 13);
    for (int i = 0; i < len; i++) txt.push_back(sextet_to_char($urandom_range(63)));
    pads = (len % 4 == 0 && $urandom_range(3) != 0) ? 0 : $urandom_range(3);
    repeat (pads) txt.push_back(PadChar);
    if (kind >= 88) begin
      foreach (txt[i]) txt[i] = 8'($urandom_range(255));
    end else if (kind >= 72) begin
      pos      = $urandom_range(txt.size() - 1);
      txt[pos] = ($urandom_range(1) == 0) ? PadChar : 8'($urandom_range(255));
    end
    foreach (txt[i]) send_char(txt[i], i == txt.size() - 1, 1'b0, NoCheck);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (exp_results.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
  endtask

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      fail_count++;
    end
  endtask

  // Sink: random stalls, plus one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        m_axis_tready <= 1'b0;
        repeat (SinkHoldCycles) @(posedge clk_i);
        hold_done = 1'b1;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    b64_result_t got;
    b64_result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready) begin
      got = '{m_axis_tdata_o, m_axis_tuser_o[0], m_axis_tlast_o, m_axis_tuser_o[1]};
      if (exp_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        fail_count++;
      end else begin
        want = exp_results.pop_front();
        check_field("data_byte", want.data, got.data);
        check_field("byte_valid", 8'(want.bvalid), 8'(got.bvalid));
        check_field("end_mark", 8'(want.endm), 8'(got.endm));
        check_field("parse_error", 8'(want.perr), 8'(got.perr));
      end
    end
  end

  // Watchdog on cycles with no transfer on either side.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= WatchdogLimit) begin
      $display("%0t: no transfer for %0d cycles, %0d results outstanding",
               $time, stuck_cycles, exp_results.size());
      $display("CHECKS FAILED");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    int unsigned phase_start;
    dir_tab = '{
      // full group "TWFu"
      '{"T", 1'b0, 1'b0, NoCheck}, '{"W", 1'b0, 1'b0, NoCheck},
      '{"F", 1'b0, 1'b0, NoCheck}, '{"u", 1'b1, 1'b0, NoCheck},
      // all-zero tail of two with padding
      '{"A", 1'b0, 1'b0, NoCheck}, '{"A", 1'b0, 1'b0, NoCheck},
      '{"=", 1'b0, 1'b0, NoCheck}, '{"=", 1'b1, 1'b0, NoCheck},
      // all-ones tail of three
      '{"/", 1'b0, 1'b0, NoCheck}, '{"/", 1'b0, 1'b0, NoCheck},
      '{"8", 1'b1, 1'b0, NoCheck},
      // lone tail characters: valid, pad, invalid at the low extreme
      '{"Q", 1'b1, 1'b1, EndOnly},
      '{"=", 1'b1, 1'b1, EndOnly},
      '{8'h00, 1'b1, 1'b1, EndOnly},
      // letter after pad, then silence until the end
      '{"A", 1'b0, 1'b0, NoCheck}, '{"=", 1'b0, 1'b0, NoCheck},
      '{"B", 1'b0, 1'b1, ErrMark}, '{"C", 1'b1, 1'b1, ErrEnd},
      // invalid character in a tail of two
      '{"A", 1'b0, 1'b0, NoCheck}, '{"*", 1'b1, 1'b1, ErrEnd},
      // invalid top-extreme character completing a group
      '{"A", 1'b0, 1'b0, NoCheck}, '{"B", 1'b0, 1'b0, NoCheck},
      '{"C", 1'b0, 1'b0, NoCheck}, '{8'hFF, 1'b0, 1'b1, ErrMark},
      '{"=", 1'b1, 1'b1, ErrEnd}
    };
    clear_decoder();
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) send_char(dir_tab[i].ch, dir_tab[i].fin, dir_tab[i].typed,
                                   dir_tab[i].want);
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 62; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 62; end
        default: begin src_idle_pct = 33; snk_stall_pct = 33; end
      endcase
      phase_start = chars_sent;
      while (chars_sent - phase_start < PhaseChars) send_string();
      wait_drained();
    end

    // Long sink hold-off with the source still offering: queue fills, input stalls.
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    hold_req <= 1'b1;
    phase_start = chars_sent;
    while (chars_sent - phase_start < 24) send_string();
    // source pauses until everything outstanding has come out
    wait_drained();
    src_idle_pct  = 33;
    snk_stall_pct = 33;
    phase_start = chars_sent;
    while (chars_sent - phase_start < 16) send_string();
    wait_drained();

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
